/* design/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/pwc_pkg.sv */
// shared types and constants of the pulse width capture fifo
package pwc_pkg;

	// ring depth, a power of two
	localparam int FIFO_DEPTH = 128;
	localparam int ADDR_W     = $clog2(FIFO_DEPTH);
	localparam int PTR_W      = ADDR_W + 1;

	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int COUNT_W    = 8;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] MIN_PULSE_RESET = 16'd250;
	localparam logic [CFG_W-1:0] MIN_GAP_RESET   = 16'd3000;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_PULSE = 2'd0,
		CFG_MIN_GAP   = 2'd1,
		CFG_ENABLE    = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_index_t;

	// input commands
	typedef enum logic {
		CMD_EDGE = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	// stream data widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	// configuration seen by the core
	typedef struct packed {
		logic [CFG_W-1:0] pulse_floor;
		logic [CFG_W-1:0] min_gap_length;
		logic             receive_enable;
	} cfg_t;

	// ring access request from the core to the storage
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [TIME_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// per-item status from the core
	typedef struct packed {
		logic             pulse_valid;
		logic             pulse_stored;
		logic             reading;
		logic [PTR_W-1:0] count;
	} core_res_t;

endpackage

/* design/rf_pulse_width_capture_fifo.sv */
// top level of the pulse width capture fifo
//
// Input stream: one transaction per edge event or pop. s_tuser carries the
// command (0 edge, 1 pop), s_tdata the edge timestamp and pin level.
// Output stream: exactly one result transaction per input transaction, in
// order, with the pop data, push flag, reading state and fifo occupancy.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per cycle;
// cfg_ready is always high. Writes are expected only while the block is idle.
// Results are registered: a result appears on m_tvalid in the cycle after its input is taken.
// Throughput: one item per cycle while results are taken; the interval subtract,
// two compares and a single ring access per item all fit between the input and
// the result register, and the ring's one read and one write port serve it.
// Stall: when m_tready is low with a result held, s_tready drops until the
// result is taken; s_tready is high again in the cycle m_tready returns.
// Reset: arst_n clears the pointers, reading state, last edge time and the
// configuration to its defaults; ring contents stay undefined until written.
module rf_pulse_width_capture_fifo
	import pwc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // edge_time[31:0], pin_level[32], zero fill
	input  logic                 s_tuser,  // command[0]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pulse_valid[0], pulse_word[32:1], pulse_stored[33], reading[34],
	// fifo_count[42:35], zero fill
	output logic [M_TDATA_W-1:0] m_tdata
);

	cfg_t              cfg_q;
	ram_req_t          ram_req;
	core_res_t         res;
	logic [TIME_W-1:0] rdata;
	logic              fire;
	logic              out_valid_q;
	core_res_t         res_q;
	logic [TIME_W-1:0] word_out;
	logic [31:0]       count_wide;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_floor    <= MIN_PULSE_RESET;
			cfg_q.min_gap_length <= MIN_GAP_RESET;
			cfg_q.receive_enable <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MIN_PULSE: cfg_q.pulse_floor    <= cfg_data;
				CFG_MIN_GAP:   cfg_q.min_gap_length <= cfg_data;
				CFG_ENABLE:    cfg_q.receive_enable <= cfg_data[0];
				CFG_UNUSED:    ;
			endcase
		end
	end

	// take a new item whenever the result register is free or being emptied
	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	pwc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.command   (s_tuser),
		.edge_time (s_tdata[TIME_W-1:0]),
		.pin_level (s_tdata[TIME_W]),
		.ram_req   (ram_req),
		.res       (res)
	);

	pwc_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	// empty pops report a zero word
	assign word_out   = res_q.pulse_valid ? rdata : '0;
	assign count_wide = 32'(res_q.count);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, count_wide[COUNT_W-1:0], res_q.reading, res_q.pulse_stored,
		word_out, res_q.pulse_valid};

endmodule

/* design/pwc_ram.sv */
// pulse storage ring: one write port, one registered read port
module pwc_ram
	import pwc_pkg::*;
(
	input  logic              clk,
	input  ram_req_t          req,
	output logic [TIME_W-1:0] rdata
);

	logic [TIME_W-1:0] mem [FIFO_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* design/pwc_core.sv */
// edge interval measurement, reading state and ring pointers
module pwc_core
	import pwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              fire,
	input  logic              command,
	input  logic [TIME_W-1:0] edge_time,
	input  logic              pin_level,
	output ram_req_t          ram_req,
	output core_res_t         res
);

	logic [TIME_W-1:0] last_edge_q;
	logic              reading_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;

	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] word;
	logic [PTR_W-1:0]  used;
	logic              empty;
	logic              full;
	logic              is_pop;
	logic              is_edge;
	logic              reading_d;
	logic              do_push;
	logic              do_pop;

	// interval word with the new pin level in the lsb
	assign diff = edge_time - last_edge_q;
	assign word = {diff[TIME_W-1:1], pin_level};

	// occupancy from pointers that run over twice the depth
	assign used  = tail_q - head_q;
	assign empty = (head_q == tail_q);
	assign full  = (used == PTR_W'(FIFO_DEPTH));

	assign is_pop  = (cmd_t'(command) == CMD_POP);
	assign is_edge = !is_pop && cfg.receive_enable;

	// minimum pulse test wins over the gap test
	always_comb begin
		reading_d = reading_q;
		if (is_edge) begin
			priority if (word < TIME_W'(cfg.pulse_floor)) begin
				reading_d = 1'b0;
			end else if (word > TIME_W'(cfg.min_gap_length)) begin
				reading_d = 1'b1;
			end else begin
				reading_d = reading_q;
			end
		end
	end

	assign do_push = is_edge && reading_d && !full;
	assign do_pop  = is_pop && !empty;

	// ring access
	always_comb begin
		ram_req.we    = fire && do_push;
		ram_req.waddr = tail_q[ADDR_W-1:0];
		ram_req.wdata = word;
		ram_req.re    = fire && do_pop;
		ram_req.raddr = head_q[ADDR_W-1:0];
	end

	// status after this item
	always_comb begin
		res.pulse_valid  = do_pop;
		res.pulse_stored = do_push;
		res.reading      = reading_d;
		res.count        = tail_q + PTR_W'(do_push) - head_q - PTR_W'(do_pop);
	end

	// state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			reading_q   <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
		end else if (fire) begin
			if (is_edge) begin
				last_edge_q <= edge_time;
				reading_q   <= reading_d;
			end
			if (do_push) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			if (do_pop) begin
				head_q <= head_q + PTR_W'(1);
			end
		end
	end

endmodule

/* design/pwc_checker.sv */
// port-level assertions for the pulse width capture fifo
`include "assert_macros.svh"

module pwc_checker
	import pwc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds its value
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a transaction is either a pop or a push, never both
	`ASSERT_IMPL(a_pop_push_excl, clk, arst_n, m_tvalid, !(m_tdata[0] && m_tdata[33]), "pop and push in one result")

	// a push happens only in the reading state
	`ASSERT_IMPL(a_push_reading, clk, arst_n, m_tvalid && m_tdata[33], m_tdata[34], "push outside reading state")

	// a result without a pop, such as an empty pop, returns a zero word
	`ASSERT_IMPL(a_empty_word, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "nonzero word without a pop")

	// an accepted item always yields a result in the next cycle
	`ASSERT_NEXT(a_one_result, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted item produced no result")

endmodule

bind rf_pulse_width_capture_fifo pwc_checker u_pwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* verif/pulse_capture_checker.sv */
// checker that predicts the pulse capture results and compares them with the block
`timescale 1ns / 1ps
module pulse_capture_checker
	import pwc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // edge_time[31:0], pin_level[32], zero fill
	input  logic                 s_tuser,  // command[0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// pulse_valid[0], pulse_word[32:1], pulse_stored[33], reading[34],
	// fifo_count[42:35], zero fill
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   fail_count,
	output int                   pending
);

	// result fields, listed from the top bit down so pulse_valid lands in bit 0
	typedef struct packed {
		logic [COUNT_W-1:0] fifo_count;
		logic               reading;
		logic               pulse_stored;
		logic [TIME_W-1:0]  pulse_word;
		logic               pulse_valid;
	} pulse_result_t;

	// predicted configuration and capture state
	logic [CFG_W-1:0]  min_pulse;
	logic [CFG_W-1:0]  min_gap;
	logic              rx_enable;
	logic [TIME_W-1:0] last_stamp;
	logic              reading_now;
	logic [TIME_W-1:0] ring [FIFO_DEPTH];
	logic [PTR_W-1:0]  head_ptr;
	logic [PTR_W-1:0]  tail_ptr;

	pulse_result_t     predicted_q[$];
	pulse_result_t     got;
	pulse_result_t     want;
	int                shown;

	// one item through the capture state, returns the result it causes
	function automatic pulse_result_t predict_result(cmd_t cmd, logic [TIME_W-1:0] stamp,
		logic level);
		pulse_result_t     r;
		logic [TIME_W-1:0] interval;
		logic [PTR_W-1:0]  used;
		r = '0;
		if (cmd == CMD_POP) begin
			// pointers run one bit wider than the slot index, equal means empty
			if (tail_ptr != head_ptr) begin
				r.pulse_valid = 1'b1;
				r.pulse_word  = ring[head_ptr[ADDR_W-1:0]];
				head_ptr      = head_ptr + 1'b1;
			end
		end else if (rx_enable) begin
			interval = ((stamp - last_stamp) & 32'hFFFF_FFFE) | TIME_W'(level);
			// short pulse test wins over the gap test
			if (interval < TIME_W'(min_pulse))
				reading_now = 1'b0;
			else if (interval > TIME_W'(min_gap))
				reading_now = 1'b1;
			used = tail_ptr - head_ptr;
			if (reading_now && used < FIFO_DEPTH) begin
				ring[tail_ptr[ADDR_W-1:0]] = interval;
				tail_ptr       = tail_ptr + 1'b1;
				r.pulse_stored = 1'b1;
			end
			last_stamp = stamp;
		end
		r.reading    = reading_now;
		r.fifo_count = tail_ptr - head_ptr;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [TIME_W-1:0] exp_val,
		logic [TIME_W-1:0] act_val);
		fail_count++;
		if (shown < 10) begin
			$display("mismatch on %s: expected %0h, actual %0h", what, exp_val, act_val);
			shown++;
		end
	endtask

	// watch the three channels, predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse   = MIN_PULSE_RESET;
			min_gap     = MIN_GAP_RESET;
			rx_enable   = 1'b0;
			last_stamp  = '0;
			reading_now = 1'b0;
			head_ptr    = '0;
			tail_ptr    = '0;
			predicted_q.delete();
			fail_count  = 0;
			shown       = 0;
			pending    <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_MIN_PULSE: min_pulse = cfg_data;
					CFG_MIN_GAP:   min_gap   = cfg_data;
					CFG_ENABLE:    rx_enable = cfg_data[0];
					default: ;
				endcase
			end
			// result transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(pulse_result_t)-1:0];
				if (predicted_q.size() == 0) begin
					fail_count++;
					if (shown < 10) begin
						$display("unexpected result transaction %0h", got);
						shown++;
					end
				end else begin
					want = predicted_q.pop_front();
					if (got.pulse_valid !== want.pulse_valid)
						note_mismatch("pulse_valid", TIME_W'(want.pulse_valid),
							TIME_W'(got.pulse_valid));
					if (got.pulse_word !== want.pulse_word)
						note_mismatch("pulse_word", want.pulse_word, got.pulse_word);
					if (got.pulse_stored !== want.pulse_stored)
						note_mismatch("pulse_stored", TIME_W'(want.pulse_stored),
							TIME_W'(got.pulse_stored));
					if (got.reading !== want.reading)
						note_mismatch("reading", TIME_W'(want.reading),
							TIME_W'(got.reading));
					if (got.fifo_count !== want.fifo_count)
						note_mismatch("fifo_count", TIME_W'(want.fifo_count),
							TIME_W'(got.fifo_count));
				end
			end
			// input transaction
			if (s_tvalid && s_tready)
				predicted_q.push_back(predict_result(cmd_t'(s_tuser), s_tdata[TIME_W-1:0],
					s_tdata[TIME_W]));
			pending <= predicted_q.size();
		end
	end

endmodule

/* verif/tb.sv */
// testbench top: edge and pop stimulus, register settings and the verdict
`timescale 1ns / 1ps
module tb;
	import pwc_pkg::*;

	localparam int PHASE_ITEMS = 190;
	localparam int STALL_LIMIT = 4000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;  // edge_time[31:0], pin_level[32], zero fill
	logic                 s_tuser   = 1'b0; // command[0]
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// pulse_valid[0], pulse_word[32:1], pulse_stored[33], reading[34],
	// fifo_count[42:35], zero fill
	logic [M_TDATA_W-1:0] m_tdata;

	int                   fail_count;
	int                   pending;
	int                   quiet_cycles = 0;

	// stimulus state
	logic [TIME_W-1:0]    now_stamp   = '0;
	logic [CFG_W-1:0]     cur_min_pulse;
	logic [CFG_W-1:0]     cur_min_gap;
	logic                 cur_enable  = 1'b0;
	int                   counted     = 0;
	int                   idle_s_pct  = 21;
	int                   idle_m_pct  = 77;

	rf_pulse_width_capture_fifo u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	pulse_capture_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= idle_m_pct);
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input transaction, with random idle cycles ahead of it
	task automatic send_item(cmd_t cmd, logic [TIME_W-1:0] stamp, logic level);
		while ($urandom_range(0, 99) < idle_s_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, level, stamp};
		do @(posedge clk); while (!s_tready);
		// edges while disabled are ignored by the block and do not count
		if (cmd == CMD_POP || cur_enable)
			counted++;
		if (counted >= 768) begin
			idle_s_pct = 0;
			idle_m_pct = 0;
		end else if (counted >= 384) begin
			idle_s_pct = 77;
			idle_m_pct = 21;
		end
	endtask

	task automatic send_edge(logic [TIME_W-1:0] delta, logic level);
		now_stamp = now_stamp + delta;
		send_item(CMD_EDGE, now_stamp, level);
	endtask

	task automatic send_pop();
		send_item(CMD_POP, $urandom, 1'($urandom_range(0, 1)));
	endtask

	// hold the input until every predicted result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// register writes, only with the block idle
	task automatic set_config(logic [CFG_W-1:0] mp, logic [CFG_W-1:0] mg, logic en);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MIN_PULSE;
		cfg_data  <= mp;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MIN_GAP;
		cfg_data  <= mg;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_ENABLE;
		cfg_data  <= CFG_W'(en);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_min_pulse = mp;
		cur_min_gap   = mg;
		cur_enable    = en;
	endtask

	// interval inside a frame, sometimes right on a threshold
	function automatic logic [TIME_W-1:0] pulse_span();
		case ($urandom_range(0, 9))
			0: return TIME_W'(cur_min_pulse) + $urandom_range(0, 1);
			1: return TIME_W'(cur_min_gap) + $urandom_range(0, 1);
			default: begin
				if (cur_min_pulse <= cur_min_gap)
					return TIME_W'(cur_min_pulse) + $urandom_range(0, cur_min_gap - cur_min_pulse);
				return $urandom_range(0, 70000);
			end
		endcase
	endfunction

	// frame start interval, now and then a huge wrapping one
	function automatic logic [TIME_W-1:0] gap_span();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return TIME_W'(cur_min_gap) + 2 + $urandom_range(0, 20000);
	endfunction

	// one random burst: a frame, noise or a run of pops
	task automatic run_burst();
		int kind;
		int n;
		int pop_pct;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// frame: a gap, pulses, sometimes a glitch at the end
			if ($urandom_range(0, 11) == 0) begin
				n       = $urandom_range(130, 170);
				pop_pct = 0;
			end else begin
				n       = $urandom_range(1, 30);
				pop_pct = 25;
			end
			send_edge(gap_span(), 1'($urandom_range(0, 1)));
			repeat (n) begin
				send_edge(pulse_span(), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 99) < pop_pct)
					send_pop();
			end
			if ($urandom_range(0, 2) == 0)
				send_edge($urandom_range(0, cur_min_pulse), 1'($urandom_range(0, 1)));
		end else if (kind < 80) begin
			// noise: edges at arbitrary times and short glitches
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 1) == 0) begin
					now_stamp = $urandom;
					send_item(CMD_EDGE, now_stamp, 1'($urandom_range(0, 1)));
				end else begin
					send_edge($urandom_range(0, 300), 1'($urandom_range(0, 1)));
				end
			end
		end else begin
			repeat ($urandom_range(1, 40)) send_pop();
		end
	endtask

	initial begin
		logic [CFG_W-1:0] mp;
		logic [CFG_W-1:0] mg;
		int               start;
		int               phase;
		bit               drained_mid;

		cur_min_pulse = MIN_PULSE_RESET;
		cur_min_gap   = MIN_GAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on empty, edge while disabled
		send_pop();
		send_item(CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
		set_config(MIN_PULSE_RESET, MIN_GAP_RESET, 1'b1);
		// gap starts reading, then pulses right on both thresholds
		send_edge(32'd5000, 1'b1);
		send_edge(32'd250, 1'b0);
		send_edge(32'd3000, 1'b0);
		// short pulses drop to idle, a mid interval keeps idle
		send_edge(32'd249, 1'b0);
		send_edge(32'd248, 1'b1);
		send_edge(32'd1000, 1'b1);
		send_edge(32'd3002, 1'b0);
		// timestamp near the top, then wrap past zero
		send_edge(32'hFFFF_FFF0 - now_stamp, 1'b1);
		send_edge(32'h210, 1'b0);
		send_edge(32'd0, 1'b1);
		// pop everything and one more on empty
		repeat (7) send_pop();
		send_edge(32'd0 - now_stamp, 1'b0);
		send_pop();

		// random phases across register settings
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(MIN_PULSE_RESET, MIN_GAP_RESET, 1'b1);
				1: set_config('0, '0, 1'b1);
				2: set_config('1, '0, 1'b1);
				3: set_config('1, '1, 1'b1);
				4: begin
					mp = CFG_W'($urandom);
					mg = CFG_W'($urandom);
					set_config(mp, mg, 1'b0);
					start = counted;
					while (counted < start + 30) run_burst();
					set_config(mp, mg, 1'b1);
				end
				default: begin
					mp = CFG_W'($urandom_range(0, 4000));
					mg = mp + CFG_W'($urandom_range(0, 30000));
					set_config(mp, mg, 1'b1);
				end
			endcase
			start       = counted;
			drained_mid = 1'b0;
			while (counted < start + PHASE_ITEMS) begin
				run_burst();
				if (!drained_mid && counted >= start + PHASE_ITEMS / 2) begin
					drain();
					drained_mid = 1'b1;
				end
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/pwc_pkg.sv
design/pwc_ram.sv
design/pwc_core.sv
design/rf_pulse_width_capture_fifo.sv
design/pwc_checker.sv
verif/pulse_capture_checker.sv
verif/tb.sv
